@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked implication checks with asynchronous reset disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMPLY(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("same-cycle implication failed");

// Next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("next-cycle implication failed");

`endif

@@ rtl/psa_pkg.sv @@
// ----------------------------------------------------------------------------
// psa_pkg
// Types and constants shared by the priority scheduler and its checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package psa_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = 5;
    localparam int THR_W       = 4;
    localparam int WAIT_W      = 4;
    localparam int ID_W        = 8;
    localparam int TIME_W      = 16;
    localparam int PRIO_W      = 8;
    localparam int WAITING_W   = 17;
    localparam int IN_W        = 56;
    localparam int OUT_W       = 80;
    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;

    localparam logic [CNT_W-1:0]         FIN_MAX   = 5'd31;
    localparam logic [THR_W-1:0]         THR_RESET = 4'd3;
    localparam logic signed [PRIO_W-1:0] PRIO_MIN  = 8'sh80;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic REG_PROC_COUNT = 1'b0;
    localparam logic REG_AGING      = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_EVAL  = 3'b010,
        ST_FINAL = 3'b100
    } state_t;

    typedef struct packed {
        logic [ID_W-1:0]          ident;
        logic [TIME_W-1:0]        arrival;
        logic [TIME_W-1:0]        burst;
        logic [TIME_W-1:0]        remaining;
        logic signed [PRIO_W-1:0] prio;
        logic [WAIT_W-1:0]        wait_cnt;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic [3:0]                  pad;
        logic signed [PRIO_W-1:0]    priority_req;
        logic [TIME_W-1:0]           burst;
        logic [TIME_W-1:0]           arrival;
        logic [ID_W-1:0]             proc_id;
        logic [IDX_W-1:0]            slot;
    } in_t;

    typedef struct packed {
        logic [3:0]                  pad;
        logic                        all_done;
        logic signed [WAITING_W-1:0] waiting;
        logic [TIME_W-1:0]           turnaround;
        logic [TIME_W-1:0]           completion_time;
        logic                        finished;
        logic [ID_W-1:0]             run_id;
        logic                        scheduled;
        logic [TIME_W-1:0]           tick_time;
    } out_t;

endpackage

@@ rtl/priority_scheduler_with_aging.sv @@
// ----------------------------------------------------------------------------
// priority_scheduler_with_aging
// A load transaction (tuser 0) writes one table entry. A tick transaction
// (tuser 1) reads the table RAM one entry per cycle for the first
// min(proc_count, 16) entries; each entry passes through one shared
// eligibility, priority-compare and aging unit, then a closing state (FINAL)
// updates the chosen entry and loads the result register. The closing state
// waits while an earlier result is still held in the output register. The
// table contents are undefined until loaded.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module priority_scheduler_with_aging (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // slot[3:0], proc_id[11:4], arrival[27:12], burst[43:28], priority_req[51:44]
    input  logic [psa_pkg::IN_W-1:0]   s_tdata,
    // cmd[0]
    input  logic [0:0]                 s_tuser,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // tick_time[15:0], scheduled[16], run_id[24:17], finished[25],
    // completion_time[41:26], turnaround[57:42], waiting[74:58], all_done[75]
    output logic [psa_pkg::OUT_W-1:0]  m_tdata,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [psa_pkg::APB_AW-1:0] paddr,
    input  logic [psa_pkg::APB_DW-1:0] pwdata,
    output logic [psa_pkg::APB_DW-1:0] prdata,
    output logic                       pready
);

    psa_pkg::state_t                   state_reg, state_next;
    logic [psa_pkg::IDX_W-1:0]         idx_reg, idx_next;
    logic [psa_pkg::CNT_W-1:0]         proc_count_reg, proc_count_next;
    logic [psa_pkg::THR_W-1:0]         aging_reg, aging_next;
    logic [psa_pkg::CNT_W-1:0]         fin_count_reg, fin_count_next;
    logic [psa_pkg::TIME_W-1:0]        tick_reg, tick_next;
    logic [psa_pkg::TIME_W-1:0]        ct_reg, ct_next;
    logic                              sel_valid_reg, sel_valid_next;
    logic signed [psa_pkg::PRIO_W-1:0] best_reg, best_next;
    psa_pkg::entry_t                   cand_reg, cand_next;
    logic [psa_pkg::IDX_W-1:0]         cand_idx_reg, cand_idx_next;
    logic [psa_pkg::TIME_W-1:0]        cand_tat_reg, cand_tat_next;
    logic                              out_valid_reg, out_valid_next;
    psa_pkg::out_t                     out_reg, out_next;

    psa_pkg::in_t                      in_item;
    psa_pkg::entry_t                   rd_entry;
    psa_pkg::entry_t                   aged;
    psa_pkg::entry_t                   load_entry;
    logic [psa_pkg::ENTRY_W-1:0]       ram_rdata;
    logic [psa_pkg::ENTRY_W-1:0]       ram_wdata;
    logic [psa_pkg::IDX_W-1:0]         ram_waddr;
    logic [psa_pkg::IDX_W-1:0]         ram_raddr;
    logic                              ram_we;

    logic                              in_fire;
    logic                              cfg_wr;
    logic [psa_pkg::CNT_W-1:0]         limit;
    logic [psa_pkg::CNT_W-1:0]         last_idx;
    logic                              eligible;
    logic                              better;
    logic [psa_pkg::WAIT_W-1:0]        wait_inc;
    logic                              age_now;
    logic                              out_free;
    logic                              fin;

    assign in_item  = psa_pkg::in_t'(s_tdata);
    assign rd_entry = psa_pkg::entry_t'(ram_rdata);
    assign s_tready = (state_reg == psa_pkg::ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign pready   = 1'b1;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;
    assign out_free = !out_valid_reg || m_tready;

    assign limit    = (proc_count_reg > psa_pkg::CNT_W'(psa_pkg::MAX_ENTRIES))
                    ? psa_pkg::CNT_W'(psa_pkg::MAX_ENTRIES) : proc_count_reg;
    assign last_idx = limit - psa_pkg::CNT_W'(1);

    assign ram_raddr = (state_reg == psa_pkg::ST_EVAL)
                     ? idx_reg + psa_pkg::IDX_W'(1) : '0;

    always_comb
    begin
        if (paddr[2] == psa_pkg::REG_AGING)
        begin
            prdata = {{(psa_pkg::APB_DW - psa_pkg::THR_W){1'b0}}, aging_reg};
        end
        else
        begin
            prdata = {{(psa_pkg::APB_DW - psa_pkg::CNT_W){1'b0}}, proc_count_reg};
        end
    end

    always_comb
    begin
        load_entry.ident     = in_item.proc_id;
        load_entry.arrival   = in_item.arrival;
        load_entry.burst     = in_item.burst;
        load_entry.remaining = in_item.burst;
        load_entry.prio      = in_item.priority_req;
        load_entry.wait_cnt  = '0;
    end

    // shared eligibility, compare and aging unit
    always_comb
    begin
        eligible = (rd_entry.arrival <= tick_reg) && (rd_entry.remaining != '0);
        better   = !sel_valid_reg || (rd_entry.prio < best_reg);
        wait_inc = rd_entry.wait_cnt + psa_pkg::WAIT_W'(1);
        age_now  = (wait_inc >= aging_reg);
        aged     = rd_entry;
        if (eligible)
        begin
            aged.wait_cnt = age_now ? '0 : wait_inc;
            if (age_now && (rd_entry.prio != psa_pkg::PRIO_MIN))
            begin
                aged.prio = rd_entry.prio - psa_pkg::PRIO_W'(1);
            end
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        proc_count_next = proc_count_reg;
        aging_next      = aging_reg;
        fin_count_next  = fin_count_reg;
        tick_next       = tick_reg;
        ct_next         = ct_reg;
        sel_valid_next  = sel_valid_reg;
        best_next       = best_reg;
        cand_next       = cand_reg;
        cand_idx_next   = cand_idx_reg;
        cand_tat_next   = cand_tat_reg;
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        ram_we          = 1'b0;
        ram_waddr       = idx_reg;
        ram_wdata       = aged;
        fin             = 1'b0;

        if (cfg_wr)
        begin
            if (paddr[2] == psa_pkg::REG_AGING)
            begin
                aging_next = pwdata[psa_pkg::THR_W-1:0];
            end
            else
            begin
                proc_count_next = pwdata[psa_pkg::CNT_W-1:0];
            end
        end

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            psa_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (s_tuser[0] == psa_pkg::CMD_LOAD)
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = in_item.slot;
                        ram_wdata = load_entry;
                    end
                    else
                    begin
                        idx_next       = '0;
                        sel_valid_next = 1'b0;
                        ct_next        = tick_reg + psa_pkg::TIME_W'(1);
                        state_next     = (limit == '0) ? psa_pkg::ST_FINAL
                                                       : psa_pkg::ST_EVAL;
                    end
                end
            end
            psa_pkg::ST_EVAL:
            begin
                ram_we    = eligible;
                ram_waddr = idx_reg;
                ram_wdata = aged;
                if (eligible && better)
                begin
                    sel_valid_next = 1'b1;
                    best_next      = rd_entry.prio;
                    cand_next      = aged;
                    cand_idx_next  = idx_reg;
                    cand_tat_next  = ct_reg - rd_entry.arrival;
                end
                if ({1'b0, idx_reg} == last_idx)
                begin
                    state_next = psa_pkg::ST_FINAL;
                end
                else
                begin
                    idx_next = idx_reg + psa_pkg::IDX_W'(1);
                end
            end
            psa_pkg::ST_FINAL:
            begin
                if (out_free)
                begin
                    fin       = sel_valid_reg && (cand_reg.remaining == psa_pkg::TIME_W'(1));
                    ram_we    = sel_valid_reg;
                    ram_waddr = cand_idx_reg;
                    ram_wdata = cand_reg;
                    ram_wdata[psa_pkg::WAIT_W + psa_pkg::PRIO_W +: psa_pkg::TIME_W] =
                        cand_reg.remaining - psa_pkg::TIME_W'(1);
                    if (fin && (fin_count_reg != psa_pkg::FIN_MAX))
                    begin
                        fin_count_next = fin_count_reg + psa_pkg::CNT_W'(1);
                    end
                    out_next.pad             = '0;
                    out_next.tick_time       = tick_reg;
                    out_next.scheduled       = sel_valid_reg;
                    out_next.run_id          = sel_valid_reg ? cand_reg.ident : '0;
                    out_next.finished        = fin;
                    out_next.completion_time = fin ? ct_reg : '0;
                    out_next.turnaround      = fin ? cand_tat_reg : '0;
                    out_next.waiting         = fin
                        ? psa_pkg::WAITING_W'({1'b0, cand_tat_reg} - {1'b0, cand_reg.burst})
                        : '0;
                    out_next.all_done        = (fin_count_next == proc_count_reg);
                    out_valid_next           = 1'b1;
                    tick_next                = ct_reg;
                    state_next               = psa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = psa_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= psa_pkg::ST_IDLE;
            idx_reg        <= '0;
            proc_count_reg <= '0;
            aging_reg      <= psa_pkg::THR_RESET;
            fin_count_reg  <= '0;
            tick_reg       <= '0;
            sel_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            proc_count_reg <= proc_count_next;
            aging_reg      <= aging_next;
            fin_count_reg  <= fin_count_next;
            tick_reg       <= tick_next;
            sel_valid_reg  <= sel_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ct_reg       <= ct_next;
        best_reg     <= best_next;
        cand_reg     <= cand_next;
        cand_idx_reg <= cand_idx_next;
        cand_tat_reg <= cand_tat_next;
        out_reg      <= out_next;
    end

    psa_ram #(
        .WIDTH (psa_pkg::ENTRY_W),
        .DEPTH (psa_pkg::MAX_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

@@ rtl/psa_ram.sv @@
// ----------------------------------------------------------------------------
// psa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module psa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/psa_checker.sv @@
// ----------------------------------------------------------------------------
// psa_checker
// Port-level checks on the priority scheduler, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module psa_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      s_tvalid,
    input logic                      s_tready,
    input logic [0:0]                s_tuser,
    input logic                      m_tvalid,
    input logic                      m_tready,
    input logic [psa_pkg::OUT_W-1:0] m_tdata
);

    psa_pkg::out_t res;
    logic          tick_fire;
    logic          idle_clear;

    assign res        = psa_pkg::out_t'(m_tdata);
    assign tick_fire  = s_tvalid && s_tready && (s_tuser[0] == psa_pkg::CMD_TICK);
    assign idle_clear = (res.run_id == '0) && (res.completion_time == '0)
                     && (res.turnaround == '0);

    `ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `ASSERT_IMPLY(a_fin_sched, clk, rst_n, m_tvalid && res.finished, res.scheduled)
    `ASSERT_IMPLY(a_idle_zero, clk, rst_n, m_tvalid && !res.scheduled, idle_clear)
    `ASSERT_NEXT(a_tick_busy, clk, rst_n, tick_fire, !s_tready)

endmodule

bind priority_scheduler_with_aging psa_checker u_checker (.*);
